### hw/rtl/nonmonotone_armijo_check_defines.svh
// Assertion macros for the Armijo line-search check block.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef NONMONOTONE_ARMIJO_CHECK_DEFINES_SVH
`define NONMONOTONE_ARMIJO_CHECK_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define NAC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define NAC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/nac_pkg.sv
// Shared types, codes and microcode ROM of the Armijo line-search check.
// Depends on nothing; used by the sequencer, datapath, history and top level.
package nac_pkg;

   // Item mode codes
   localparam logic [1:0] MODE_SETUP = 2'd0;
   localparam logic [1:0] MODE_SKIP  = 2'd1;
   localparam logic [1:0] MODE_EVAL  = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_UNEVAL     = 2'd0;
   localparam logic [1:0] STATUS_NODESC     = 2'd1;
   localparam logic [1:0] STATUS_SUFFICIENT = 2'd2;
   localparam logic [1:0] STATUS_TOOLONG    = 2'd3;

   typedef logic [3:0] nac_pc_type;

   // Microcode addresses
   localparam nac_pc_type ADDR_SETUP      = 4'd0;
   localparam nac_pc_type ADDR_CHECK_MODE = 4'd1;
   localparam nac_pc_type ADDR_PUSH       = 4'd2;
   localparam nac_pc_type ADDR_SCAN       = 4'd3;
   localparam nac_pc_type ADDR_CLEAR      = 4'd4;
   localparam nac_pc_type ADDR_NODESC     = 4'd5;
   localparam nac_pc_type ADDR_EVAL       = 4'd6;
   localparam nac_pc_type ADDR_MUL_CS     = 4'd7;
   localparam nac_pc_type ADDR_MUL_MAG    = 4'd8;
   localparam nac_pc_type ADDR_DECIDE     = 4'd9;
   localparam nac_pc_type ADDR_REPORT     = 4'd10;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_PUSH,
      OP_SCAN,
      OP_CLEAR,
      OP_NODESC,
      OP_MUL_CS,
      OP_MUL_MAG,
      OP_DECIDE
   } nac_op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_SLOPE_NONNEG,
      COND_MONOTONE,
      COND_NODESC,
      COND_SCAN_MORE
   } nac_cond_type;

   typedef struct packed {
      nac_op_type   op;
      nac_cond_type cond;
      nac_pc_type   target;
      logic         last;
   } nac_uword_type;

   // Control handed from sequencer to datapath and history
   typedef struct packed {
      logic       exec;
      nac_op_type op;
      logic       last;
   } nac_ctrl_type;

   // Branch conditions handed back to the sequencer
   typedef struct packed {
      logic slope_nonneg;
      logic monotone;
      logic nodesc;
      logic scan_more;
   } nac_flags_type;

   // Control store
   function automatic nac_uword_type nac_rom(input nac_pc_type pc);
      nac_uword_type uw;
      unique case (pc)
         ADDR_SETUP:      uw = '{OP_LOAD,    COND_SLOPE_NONNEG, ADDR_NODESC, 1'b0};
         ADDR_CHECK_MODE: uw = '{OP_NOP,     COND_MONOTONE,     ADDR_CLEAR,  1'b0};
         ADDR_PUSH:       uw = '{OP_PUSH,    COND_NEVER,        ADDR_SETUP,  1'b0};
         ADDR_SCAN:       uw = '{OP_SCAN,    COND_SCAN_MORE,    ADDR_SCAN,   1'b0};
         ADDR_CLEAR:      uw = '{OP_CLEAR,   COND_NEVER,        ADDR_SETUP,  1'b1};
         ADDR_NODESC:     uw = '{OP_NODESC,  COND_NEVER,        ADDR_SETUP,  1'b1};
         ADDR_EVAL:       uw = '{OP_NOP,     COND_NODESC,       ADDR_REPORT, 1'b0};
         ADDR_MUL_CS:     uw = '{OP_MUL_CS,  COND_NEVER,        ADDR_SETUP,  1'b0};
         ADDR_MUL_MAG:    uw = '{OP_MUL_MAG, COND_NEVER,        ADDR_SETUP,  1'b0};
         ADDR_DECIDE:     uw = '{OP_DECIDE,  COND_NEVER,        ADDR_SETUP,  1'b1};
         default:         uw = '{OP_NOP,     COND_NEVER,        ADDR_SETUP,  1'b1};
      endcase
      return uw;
   endfunction

   // Entry point of the program for each item mode
   function automatic nac_pc_type nac_dispatch(input logic [1:0] mode);
      nac_pc_type pc;
      unique case (mode)
         MODE_SETUP: pc = ADDR_SETUP;
         MODE_SKIP:  pc = ADDR_CLEAR;
         MODE_EVAL:  pc = ADDR_EVAL;
         default:    pc = ADDR_REPORT;
      endcase
      return pc;
   endfunction

endpackage

### hw/rtl/nac_seq.sv
// Microcode sequencer: step counter, control store lookup and branching.
// Depends on nac_pkg.
module nac_seq
   import nac_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    mode,
   input  nac_flags_type flags,
   input  logic          out_hold,
   output logic          busy,
   output nac_ctrl_type  ctrl
);

   logic          busy_ff, busy_in;
   nac_pc_type    pc_ff, pc_in;
   nac_uword_type uw;
   logic          cond_true;

   // Decode the current control word
   always_comb begin
      uw = nac_rom(pc_ff);
      unique case (uw.cond)
         COND_SLOPE_NONNEG: cond_true = flags.slope_nonneg;
         COND_MONOTONE:     cond_true = flags.monotone;
         COND_NODESC:       cond_true = flags.nodesc;
         COND_SCAN_MORE:    cond_true = flags.scan_more;
         default:           cond_true = 1'b0;
      endcase
      // hold the final step while the previous result still waits
      ctrl.exec = busy_ff & ~(uw.last & out_hold);
      ctrl.op   = uw.op;
      ctrl.last = uw.last;
   end

   // Advance the step counter
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = nac_dispatch(mode);
      end else if (ctrl.exec) begin
         if (uw.last) begin
            busy_in = 1'b0;
         end else if (cond_true) begin
            pc_in = uw.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= ADDR_SETUP;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy = busy_ff;

endmodule

### hw/rtl/nac_hist.sv
// History window of past reference merits: circular buffer, count and max scan.
// Depends on nac_pkg.
module nac_hist
   import nac_pkg::*;
#(
   parameter int HIST_DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  nac_ctrl_type       ctrl,
   input  logic signed [31:0] merit,
   input  logic [3:0]         history_limit,
   output logic               scan_more,
   output logic               rd_valid,
   output logic signed [31:0] rd_data
);

   localparam int AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int CW = $clog2(HIST_DEPTH + 1);
   localparam int LW = (CW > 4) ? CW : 4;

   logic signed [31:0] mem [HIST_DEPTH];

   logic [AW-1:0]      head_ff, head_in, head_new;
   logic [CW-1:0]      count_ff, count_in, count_new, lim;
   logic [AW-1:0]      scan_addr_ff, scan_addr_in, base;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic               pend_ff, pend_in;
   logic signed [31:0] newest_ff;
   logic signed [31:0] rd_data_ff;
   logic [LW-1:0]      lim_wide;
   logic [CW:0]        count_sum;
   logic               push_en, issue;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
      return (a == AW'(HIST_DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   // Clamp the configured limit to 1..HIST_DEPTH
   always_comb begin
      lim_wide = LW'(history_limit);
      if (lim_wide == '0) begin
         lim_wide = LW'(1);
      end
      if (lim_wide > LW'(HIST_DEPTH)) begin
         lim_wide = LW'(HIST_DEPTH);
      end
      lim = lim_wide[CW-1:0];
   end

   // Push decision, new head and bounded count
   always_comb begin
      push_en   = ctrl.exec && (ctrl.op == OP_PUSH) &&
                  ((count_ff == '0) || (merit != newest_ff));
      head_new  = (head_ff == '0) ? AW'(HIST_DEPTH - 1) : head_ff - 1'b1;
      count_sum = {1'b0, count_ff} + 1'b1;
      count_new = (count_sum > {1'b0, lim}) ? lim : count_sum[CW-1:0];
      base      = push_en ? head_new : head_ff;
      scan_more = scan_idx_ff < count_ff;
      issue     = ctrl.exec && (ctrl.op == OP_SCAN) && scan_more;
   end

   // Scan pointers: entry 0 is the merit itself, so start at entry 1
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      scan_addr_in = scan_addr_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = pend_ff;
      if (ctrl.exec && (ctrl.op == OP_PUSH)) begin
         if (push_en) begin
            head_in  = head_new;
            count_in = count_new;
         end
         scan_addr_in = wrap_inc(base);
         scan_idx_in  = CW'(1);
         pend_in      = 1'b0;
      end else if (ctrl.exec && (ctrl.op == OP_SCAN)) begin
         pend_in = issue;
         if (issue) begin
            scan_addr_in = wrap_inc(scan_addr_ff);
            scan_idx_in  = scan_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         scan_addr_ff <= '0;
         scan_idx_ff  <= '0;
         pend_ff      <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         scan_addr_ff <= scan_addr_in;
         scan_idx_ff  <= scan_idx_in;
         pend_ff      <= pend_in;
      end
   end

   // Window storage, one write and one registered read port
   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[head_new] <= merit;
         newest_ff     <= merit;
      end
      if (issue) begin
         rd_data_ff <= mem[scan_addr_ff];
      end
   end

   assign rd_valid = pend_ff;
   assign rd_data  = rd_data_ff;

endmodule

### hw/rtl/nac_dp.sv
// Datapath: item registers, reference and slope, shared multiplier, Armijo compare.
// Depends on nac_pkg.
module nac_dp
   import nac_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] merit_value,
   input  logic signed [31:0] descent_slope,
   input  logic [15:0]        step_length,
   input  nac_ctrl_type       ctrl,
   input  logic [15:0]        decrease_factor,
   input  logic               rd_valid,
   input  logic signed [31:0] rd_data,
   output logic signed [31:0] merit_item,
   output logic               slope_nonneg,
   output logic               nodesc,
   output logic [1:0]         status_next
);

   logic signed [31:0] merit_ff, slope_item_ff;
   logic [15:0]        step_ff;
   logic signed [31:0] ref_ff, ref_in;
   logic signed [31:0] slope_ff, slope_in;
   logic [1:0]         status_ff;
   logic [63:0]        prod_ff;
   logic signed [32:0] diff_ff;
   logic [31:0]        slope_mag, mult_a, mult_b;
   logic [63:0]        mult;
   logic [32:0]        quot;
   logic signed [33:0] thr, diff_wide;
   logic               load_prod, load_diff;

   // Shared multiplier: c1*step first, then that product times |slope|
   always_comb begin
      slope_mag = slope_ff[31] ? 32'(-slope_ff) : 32'(slope_ff);
      if (ctrl.op == OP_MUL_MAG) begin
         mult_a = prod_ff[31:0];
         mult_b = slope_mag;
      end else begin
         mult_a = {16'd0, decrease_factor};
         mult_b = {16'd0, step_ff};
      end
      mult = mult_a * mult_b;
   end

   // Threshold with 31 fraction bits dropped, rounded up (ceiling) for either slope sign
   always_comb begin
      quot = prod_ff[63:31];
      if (slope_ff[31]) begin
         thr = 34'sd0 - $signed({1'b0, quot});
      end else begin
         thr = $signed({1'b0, quot}) + $signed(34'(|prod_ff[30:0]));
      end
      diff_wide = {diff_ff[32], diff_ff};
   end

   // Reference, slope and status updates per micro-op
   always_comb begin
      ref_in      = ref_ff;
      slope_in    = slope_ff;
      status_next = status_ff;
      load_prod   = 1'b0;
      load_diff   = 1'b0;
      if (ctrl.exec) begin
         unique case (ctrl.op)
            OP_LOAD: begin
               ref_in   = merit_ff;
               slope_in = slope_item_ff;
            end
            OP_SCAN: begin
               if (rd_valid && (rd_data > ref_ff)) begin
                  ref_in = rd_data;
               end
            end
            OP_CLEAR:   status_next = STATUS_UNEVAL;
            OP_NODESC:  status_next = STATUS_NODESC;
            OP_MUL_CS: begin
               load_prod = 1'b1;
               load_diff = 1'b1;
            end
            OP_MUL_MAG: load_prod = 1'b1;
            OP_DECIDE:  status_next = (diff_wide < thr) ? STATUS_SUFFICIENT : STATUS_TOOLONG;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff    <= '0;
         slope_ff  <= '0;
         status_ff <= STATUS_UNEVAL;
      end else begin
         ref_ff    <= ref_in;
         slope_ff  <= slope_in;
         status_ff <= status_next;
      end
   end

   // Capture the transaction and intermediate products
   always_ff @(posedge clock) begin
      if (start) begin
         merit_ff      <= merit_value;
         slope_item_ff <= descent_slope;
         step_ff       <= step_length;
      end
      if (load_prod) begin
         prod_ff <= mult;
      end
      if (load_diff) begin
         diff_ff <= {merit_ff[31], merit_ff} - {ref_ff[31], ref_ff};
      end
   end

   assign merit_item   = merit_ff;
   assign slope_nonneg = ~slope_item_ff[31];
   assign nodesc       = (status_ff == STATUS_NODESC);

endmodule

### hw/rtl/nonmonotone_armijo_check.sv
// Non-monotone Armijo sufficient-decrease check, top level.
// Depends on nac_pkg, nac_seq, nac_hist, nac_dp and the assertion macro header.
//
// Usage:
//   req_* carries one transaction: mode (setup, skip, evaluate), merit, slope
//   and step, taken when req_valid is high and req_stall is low. rsp_* returns
//   one status per transaction, taken when rsp_valid is high and rsp_stall is
//   low. csr_* writes decrease_factor (0), monotone_mode (1) and history_limit
//   (2); csr_ready is high whenever reset is low.
// Sequence (microcode steps per transaction):
//   skip or unused mode: the final step only; setup: load reference and slope,
//   then no descent for a non-negative slope, clear in monotone mode, else push
//   and scan the window through the single history read port, then clear;
//   evaluate: the shared 32x32 multiplier twice, then the compare, or report
//   under no descent. The result is valid the cycle after the last step and
//   the next transaction can be taken in that cycle.
// Reset: synchronous; history empty, reference and slope zero, status
//   unevaluated, registers at defaults; req_stall is held high during reset.
// Stall: the finished result waits in the output register; a following
//   transaction runs up to its last step and holds there for the slot.
`include "nonmonotone_armijo_check_defines.svh"

module nonmonotone_armijo_check
   import nac_pkg::*;
#(
   parameter int HIST_DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_merit_value,
   input  logic signed [31:0] req_descent_slope,
   input  logic [15:0]        req_step_length,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_test_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam logic [1:0] CSR_DECREASE_FACTOR = 2'd0;
   localparam logic [1:0] CSR_MONOTONE_MODE   = 2'd1;
   localparam logic [1:0] CSR_HISTORY_LIMIT   = 2'd2;

   logic [15:0]        decrease_factor_ff;
   logic               monotone_mode_ff;
   logic [3:0]         history_limit_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic               busy, start;
   nac_ctrl_type       ctrl;
   nac_flags_type      flags;
   logic signed [31:0] merit_item, rd_data;
   logic               rd_valid, scan_more, slope_nonneg, nodesc;
   logic [1:0]         status_next;

   assign req_stall = busy | reset;
   assign start     = req_valid & ~req_stall;
   assign csr_ready = ~reset;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         decrease_factor_ff <= 16'd7;
         monotone_mode_ff   <= 1'b1;
         history_limit_ff   <= 4'd8;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DECREASE_FACTOR: decrease_factor_ff <= csr_wdata;
            CSR_MONOTONE_MODE:   monotone_mode_ff   <= csr_wdata[0];
            CSR_HISTORY_LIMIT:   history_limit_ff   <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      flags.slope_nonneg = slope_nonneg;
      flags.monotone     = monotone_mode_ff;
      flags.nodesc       = nodesc;
      flags.scan_more    = scan_more;
   end

   nac_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .mode     (req_mode),
      .flags    (flags),
      .out_hold (rsp_valid_ff & rsp_stall),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   nac_hist #(
      .HIST_DEPTH (HIST_DEPTH)
   ) u_hist (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .merit         (merit_item),
      .history_limit (history_limit_ff),
      .scan_more     (scan_more),
      .rd_valid      (rd_valid),
      .rd_data       (rd_data)
   );

   nac_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .merit_value     (req_merit_value),
      .descent_slope   (req_descent_slope),
      .step_length     (req_step_length),
      .ctrl            (ctrl),
      .decrease_factor (decrease_factor_ff),
      .rd_valid        (rd_valid),
      .rd_data         (rd_data),
      .merit_item      (merit_item),
      .slope_nonneg    (slope_nonneg),
      .nodesc          (nodesc),
      .status_next     (status_next)
   );

   // Output register: load on the last step, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.exec && ctrl.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec && ctrl.last) begin
         rsp_status_ff <= status_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_test_status = rsp_status_ff;

   // Checks
   `NAC_ASSERT_NXT(a_accept_sets_busy, req_valid && !req_stall, req_stall,
                   "accepted transaction did not start the sequencer")
   `NAC_ASSERT_IMP(a_rsp_follows_work, $rose(rsp_valid), $past(req_stall),
                   "result appeared without a transaction in progress")
   `NAC_ASSERT_IMP(a_no_overwrite, ctrl.exec && ctrl.last, !(rsp_valid && rsp_stall),
                   "last step ran while a stalled result was pending")

endmodule
